### design/ahse_pkg.sv
// Shared types, constants and microprogram for the handshaked SPI exchange block.
package ahse_pkg;

   localparam int BufferBytes = 32;
   localparam int AddrW = $clog2(BufferBytes);
   localparam int PosW = $clog2(BufferBytes + 1);
   localparam int IdxW = 5;
   localparam int IdxExtW = ((AddrW > IdxW) ? AddrW : IdxW) + 1;
   localparam int CountW = 9;
   localparam int TickW = 16;
   localparam int PcW = 5;
   localparam logic [TickW-1:0] TimeoutReset = 16'd65;
   localparam logic [CountW-1:0] ShortCount = 9'd2;

   typedef enum logic [2:0] {
      REQ_WRITE     = 3'd0,
      REQ_READ      = 3'd1,
      REQ_START     = 3'd2,
      REQ_TICK      = 3'd3,
      REQ_BYTE_DONE = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_XFER = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_WAIT    = 3'd1,
      ST_XFER    = 3'd2,
      ST_DONE    = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_NOTHING = 3'd5
   } status_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_WR_IDX,
      UOP_RD_IDX,
      UOP_LATCH_READ,
      UOP_CLEAR,
      UOP_START_WAIT,
      UOP_BEGIN_COUNT,
      UOP_BEGIN_TWO,
      UOP_BEGIN_LEFT,
      UOP_TIMEOUT,
      UOP_TICK_INC,
      UOP_NOTHING,
      UOP_BYTE_WR,
      UOP_BYTE_DONE,
      UOP_RD_POS,
      UOP_SEND_POS
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_WR_OK,
      COND_IDX_OK,
      COND_BUSY,
      COND_BUF0_NZ,
      COND_READY_LOW,
      COND_NOT_WAIT,
      COND_TIMEOUT,
      COND_NOT_XFER,
      COND_XFER_END
   } cond_type;

   typedef struct packed {
      uop_type        op;
      cond_type       cond;
      logic [PcW-1:0] target;
      logic           emit;
   } ucode_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [4:0] buffer_index;
      logic [7:0] data_byte;
      logic       ready_level;
   } req_data_type;

   typedef struct packed {
      logic       request_level;
      logic       send_valid;
      logic [7:0] send_byte;
      logic [7:0] read_byte;
      logic [2:0] status;
      logic       retry_needed;
      logic       busy_res;
   } rsp_data_type;

   localparam logic [PcW-1:0] PcWrite    = 5'd0;
   localparam logic [PcW-1:0] PcWrDo     = 5'd2;
   localparam logic [PcW-1:0] PcRead     = 5'd3;
   localparam logic [PcW-1:0] PcIgnore   = 5'd4;
   localparam logic [PcW-1:0] PcRdDo     = 5'd5;
   localparam logic [PcW-1:0] PcStart    = 5'd7;
   localparam logic [PcW-1:0] PcBeginTwo = 5'd11;
   localparam logic [PcW-1:0] PcFull     = 5'd12;
   localparam logic [PcW-1:0] PcBeginCnt = 5'd14;
   localparam logic [PcW-1:0] PcTick     = 5'd15;
   localparam logic [PcW-1:0] PcBeginLft = 5'd19;
   localparam logic [PcW-1:0] PcTimeout  = 5'd20;
   localparam logic [PcW-1:0] PcByte     = 5'd21;
   localparam logic [PcW-1:0] PcByteEnd  = 5'd26;

   function automatic ucode_type uw(uop_type op, cond_type cond,
                                    logic [PcW-1:0] target, logic emit);
      ucode_type w;
      w.op = op;
      w.cond = cond;
      w.target = target;
      w.emit = emit;
      return w;
   endfunction

   function automatic logic [PcW-1:0] entry(logic [2:0] kind);
      logic [PcW-1:0] pc;
      unique case (kind)
         REQ_WRITE:     pc = PcWrite;
         REQ_READ:      pc = PcRead;
         REQ_START:     pc = PcStart;
         REQ_TICK:      pc = PcTick;
         REQ_BYTE_DONE: pc = PcByte;
         default:       pc = PcIgnore;
      endcase
      return pc;
   endfunction

   function automatic ucode_type ucode(logic [PcW-1:0] pc);
      ucode_type w;
      unique case (pc)
         5'd0:    w = uw(UOP_NOP,         COND_WR_OK,     PcWrDo,     1'b0);
         5'd1:    w = uw(UOP_NOP,         COND_NEVER,     PcIgnore,   1'b1);
         5'd2:    w = uw(UOP_WR_IDX,      COND_NEVER,     PcIgnore,   1'b1);
         5'd3:    w = uw(UOP_NOP,         COND_IDX_OK,    PcRdDo,     1'b0);
         5'd4:    w = uw(UOP_NOP,         COND_NEVER,     PcIgnore,   1'b1);
         5'd5:    w = uw(UOP_RD_IDX,      COND_NEVER,     PcIgnore,   1'b0);
         5'd6:    w = uw(UOP_LATCH_READ,  COND_NEVER,     PcIgnore,   1'b1);
         5'd7:    w = uw(UOP_NOP,         COND_BUSY,      PcIgnore,   1'b0);
         5'd8:    w = uw(UOP_NOP,         COND_BUF0_NZ,   PcFull,     1'b0);
         5'd9:    w = uw(UOP_CLEAR,       COND_READY_LOW, PcBeginTwo, 1'b0);
         5'd10:   w = uw(UOP_NOTHING,     COND_NEVER,     PcIgnore,   1'b1);
         5'd11:   w = uw(UOP_BEGIN_TWO,   COND_NEVER,     PcIgnore,   1'b1);
         5'd12:   w = uw(UOP_NOP,         COND_READY_LOW, PcBeginCnt, 1'b0);
         5'd13:   w = uw(UOP_START_WAIT,  COND_NEVER,     PcIgnore,   1'b1);
         5'd14:   w = uw(UOP_BEGIN_COUNT, COND_NEVER,     PcIgnore,   1'b1);
         5'd15:   w = uw(UOP_NOP,         COND_NOT_WAIT,  PcIgnore,   1'b0);
         5'd16:   w = uw(UOP_NOP,         COND_READY_LOW, PcBeginLft, 1'b0);
         5'd17:   w = uw(UOP_NOP,         COND_TIMEOUT,   PcTimeout,  1'b0);
         5'd18:   w = uw(UOP_TICK_INC,    COND_NEVER,     PcIgnore,   1'b1);
         5'd19:   w = uw(UOP_BEGIN_LEFT,  COND_NEVER,     PcIgnore,   1'b1);
         5'd20:   w = uw(UOP_TIMEOUT,     COND_NEVER,     PcIgnore,   1'b1);
         5'd21:   w = uw(UOP_NOP,         COND_NOT_XFER,  PcIgnore,   1'b0);
         5'd22:   w = uw(UOP_BYTE_WR,     COND_NEVER,     PcIgnore,   1'b0);
         5'd23:   w = uw(UOP_NOP,         COND_XFER_END,  PcByteEnd,  1'b0);
         5'd24:   w = uw(UOP_RD_POS,      COND_NEVER,     PcIgnore,   1'b0);
         5'd25:   w = uw(UOP_SEND_POS,    COND_NEVER,     PcIgnore,   1'b1);
         5'd26:   w = uw(UOP_BYTE_DONE,   COND_NEVER,     PcIgnore,   1'b1);
         default: w = uw(UOP_NOP,         COND_NEVER,     PcIgnore,   1'b1);
      endcase
      return w;
   endfunction

endpackage

### design/ahse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ahse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/aci_handshake_spi_exchange_top.sv
// Top level: microcoded master for a request/ready handshaked SPI byte exchange.
//
// Each request beat is run by a short microprogram and yields one response beat.
// One beat is in flight at a time. The program length and the registered read of the
// message buffer RAM set the time from acceptance to response, and a full output
// register stalls the final step. A new request is taken while the previous response
// still waits in the output register. The message buffer reads as zero after reset
// and after a start with an empty buffer through per-slot valid bits, so no clearing
// pass is needed. The user must write the timeout register through the csr port only
// while the block is idle; the block itself does not enforce this.
module aci_handshake_spi_exchange_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ahse_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ahse_pkg::rsp_data_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);

   localparam int AddrW = ahse_pkg::AddrW;
   localparam int PosW = ahse_pkg::PosW;
   localparam int CountW = ahse_pkg::CountW;
   localparam int TickW = ahse_pkg::TickW;
   localparam int PcW = ahse_pkg::PcW;
   localparam int IdxExtW = ahse_pkg::IdxExtW;
   localparam int Bytes = ahse_pkg::BufferBytes;

   ahse_pkg::seq_state_type state_ff, state_in;
   logic [PcW-1:0]          pc_ff, pc_in;
   ahse_pkg::req_data_type  req_ff, req_in;
   logic [TickW-1:0]        timeout_ff, timeout_in;
   ahse_pkg::phase_type     phase_ff, phase_in;
   logic [CountW-1:0]       left_ff, left_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic [TickW-1:0]        wait_ff, wait_in;
   logic                    retry_ff, retry_in;
   logic                    request_ff, request_in;
   logic [7:0]              buf0_ff, buf0_in;
   logic [Bytes-1:0]        valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    send_valid_ff, send_valid_in;
   logic [7:0]              send_byte_ff, send_byte_in;
   logic [7:0]              read_byte_ff, read_byte_in;
   logic                    ovr_ff, ovr_in;
   ahse_pkg::status_type    code_ff, code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ahse_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   ahse_pkg::ucode_type     word;
   logic                    running;
   logic                    req_accept;
   logic                    fire;
   logic                    cond_true;
   logic [IdxExtW-1:0]      idx_ext;
   logic                    idx_ok;
   logic [AddrW-1:0]        idx_addr;
   logic [AddrW-1:0]        pos_addr;
   logic [CountW-1:0]       left_dec;
   logic [7:0]              rd_byte;
   logic                    ram_wr_en;
   logic [AddrW-1:0]        ram_wr_addr;
   logic                    ram_rd_en;
   logic [AddrW-1:0]        ram_rd_addr;
   logic [7:0]              ram_rd_data;

   assign word = ahse_pkg::ucode(pc_ff);
   assign req_accept = req_valid && req_ready;
   assign fire = running && !(word.emit && rsp_valid_ff && !rsp_ready);
   assign idx_ext = IdxExtW'(req_ff.buffer_index);
   assign idx_ok = idx_ext < IdxExtW'(Bytes);
   assign idx_addr = idx_ext[AddrW-1:0];
   assign pos_addr = pos_ff[AddrW-1:0];
   assign left_dec = (left_ff == '0) ? '0 : left_ff - CountW'(1);
   assign rd_byte = rd_valid_ff ? ram_rd_data : 8'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ahse_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               state_in = ahse_pkg::SEQ_RUN;
            end
         end
         ahse_pkg::SEQ_RUN: begin
            if (fire && word.emit) begin
               state_in = ahse_pkg::SEQ_IDLE;
            end
         end
         default: state_in = ahse_pkg::SEQ_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      running = 1'b0;
      unique case (state_ff)
         ahse_pkg::SEQ_IDLE: req_ready = 1'b1;
         ahse_pkg::SEQ_RUN:  running = 1'b1;
         default:            req_ready = 1'b0;
      endcase
   end

   always_comb begin
      unique case (word.cond)
         ahse_pkg::COND_NEVER:     cond_true = 1'b0;
         ahse_pkg::COND_WR_OK:     cond_true = (phase_ff == ahse_pkg::PH_IDLE) && idx_ok;
         ahse_pkg::COND_IDX_OK:    cond_true = idx_ok;
         ahse_pkg::COND_BUSY:      cond_true = phase_ff != ahse_pkg::PH_IDLE;
         ahse_pkg::COND_BUF0_NZ:   cond_true = buf0_ff != 8'd0;
         ahse_pkg::COND_READY_LOW: cond_true = !req_ff.ready_level;
         ahse_pkg::COND_NOT_WAIT:  cond_true = phase_ff != ahse_pkg::PH_WAIT;
         ahse_pkg::COND_TIMEOUT:   cond_true = wait_ff >= timeout_ff;
         ahse_pkg::COND_NOT_XFER:  cond_true = phase_ff != ahse_pkg::PH_XFER;
         ahse_pkg::COND_XFER_END:  cond_true = (pos_ff >= PosW'(Bytes)) || (left_ff == '0);
         default:                  cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      req_in = req_ff;
      timeout_in = timeout_ff;
      phase_in = phase_ff;
      left_in = left_ff;
      pos_in = pos_ff;
      wait_in = wait_ff;
      retry_in = retry_ff;
      request_in = request_ff;
      buf0_in = buf0_ff;
      valid_in = valid_ff;
      rd_valid_in = rd_valid_ff;
      send_valid_in = send_valid_ff;
      send_byte_in = send_byte_ff;
      read_byte_in = read_byte_ff;
      ovr_in = ovr_ff;
      code_in = code_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = idx_addr;
      ram_rd_en = 1'b0;
      ram_rd_addr = idx_addr;

      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end

      if (req_accept) begin
         req_in = req_data;
         pc_in = ahse_pkg::entry(req_data.req_type);
         send_valid_in = 1'b0;
         send_byte_in = 8'd0;
         read_byte_in = 8'd0;
         ovr_in = 1'b0;
         code_in = ahse_pkg::ST_IDLE;
      end

      if (fire) begin
         pc_in = cond_true ? word.target : pc_ff + PcW'(1);
         case (word.op) inside
            ahse_pkg::UOP_WR_IDX: begin
               ram_wr_en = 1'b1;
               valid_in[idx_addr] = 1'b1;
               if (idx_addr == '0) begin
                  buf0_in = req_ff.data_byte;
               end
            end
            ahse_pkg::UOP_RD_IDX: begin
               ram_rd_en = 1'b1;
               rd_valid_in = valid_ff[idx_addr];
            end
            ahse_pkg::UOP_LATCH_READ: read_byte_in = rd_byte;
            ahse_pkg::UOP_CLEAR: begin
               valid_in = '0;
               buf0_in = 8'd0;
            end
            ahse_pkg::UOP_START_WAIT: begin
               request_in = 1'b0;
               wait_in = '0;
               left_in = CountW'(buf0_ff) + CountW'(1);
               phase_in = ahse_pkg::PH_WAIT;
            end
            ahse_pkg::UOP_BEGIN_COUNT, ahse_pkg::UOP_BEGIN_TWO,
            ahse_pkg::UOP_BEGIN_LEFT: begin
               if (word.op == ahse_pkg::UOP_BEGIN_COUNT) begin
                  wait_in = '0;
                  left_in = CountW'(buf0_ff) + CountW'(1);
               end else if (word.op == ahse_pkg::UOP_BEGIN_TWO) begin
                  left_in = ahse_pkg::ShortCount;
               end
               if (word.op != ahse_pkg::UOP_BEGIN_TWO) begin
                  retry_in = 1'b0;
               end
               request_in = 1'b0;
               phase_in = ahse_pkg::PH_XFER;
               pos_in = '0;
               send_valid_in = 1'b1;
               send_byte_in = buf0_ff;
            end
            ahse_pkg::UOP_TIMEOUT: begin
               request_in = 1'b1;
               retry_in = 1'b1;
               phase_in = ahse_pkg::PH_IDLE;
               wait_in = '0;
               ovr_in = 1'b1;
               code_in = ahse_pkg::ST_TIMEOUT;
            end
            ahse_pkg::UOP_TICK_INC: wait_in = wait_ff + TickW'(1);
            ahse_pkg::UOP_NOTHING: begin
               ovr_in = 1'b1;
               code_in = ahse_pkg::ST_NOTHING;
            end
            ahse_pkg::UOP_BYTE_WR: begin
               ram_wr_en = 1'b1;
               ram_wr_addr = pos_addr;
               valid_in[pos_addr] = 1'b1;
               if (pos_ff == '0) begin
                  buf0_in = req_ff.data_byte;
               end
               left_in = left_dec;
               if (pos_ff == PosW'(1) && CountW'(req_ff.data_byte) > left_dec) begin
                  left_in = CountW'(req_ff.data_byte);
               end
               pos_in = pos_ff + PosW'(1);
            end
            ahse_pkg::UOP_BYTE_DONE: begin
               request_in = 1'b1;
               buf0_in = 8'd0;
               valid_in[0] = 1'b0;
               phase_in = ahse_pkg::PH_IDLE;
               ovr_in = 1'b1;
               code_in = ahse_pkg::ST_DONE;
            end
            ahse_pkg::UOP_RD_POS: begin
               ram_rd_en = 1'b1;
               ram_rd_addr = pos_addr;
               rd_valid_in = valid_ff[pos_addr];
            end
            ahse_pkg::UOP_SEND_POS: begin
               send_valid_in = 1'b1;
               send_byte_in = rd_byte;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (fire && word.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.request_level = request_in;
         rsp_data_in.send_valid = send_valid_in;
         rsp_data_in.send_byte = send_byte_in;
         rsp_data_in.read_byte = read_byte_in;
         rsp_data_in.status = ovr_in ? code_in : 3'(phase_in);
         rsp_data_in.retry_needed = retry_in;
         rsp_data_in.busy_res = phase_in != ahse_pkg::PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ahse_pkg::SEQ_IDLE;
         timeout_ff <= ahse_pkg::TimeoutReset;
         phase_ff <= ahse_pkg::PH_IDLE;
         left_ff <= '0;
         pos_ff <= '0;
         wait_ff <= '0;
         retry_ff <= 1'b0;
         request_ff <= 1'b1;
         buf0_ff <= 8'd0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         timeout_ff <= timeout_in;
         phase_ff <= phase_in;
         left_ff <= left_in;
         pos_ff <= pos_in;
         wait_ff <= wait_in;
         retry_ff <= retry_in;
         request_ff <= request_in;
         buf0_ff <= buf0_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pc_ff <= pc_in;
      req_ff <= req_in;
      rd_valid_ff <= rd_valid_in;
      send_valid_ff <= send_valid_in;
      send_byte_ff <= send_byte_in;
      read_byte_ff <= read_byte_in;
      ovr_ff <= ovr_in;
      code_ff <= code_in;
      rsp_data_ff <= rsp_data_in;
   end

   ahse_ram #(
      .WIDTH(8),
      .DEPTH(Bytes)
   ) u_buffer (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_ff.data_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
